### design/sortable_search_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// Sortable search FIFO assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SORTABLE_SEARCH_FIFO_TOP_DEFINES_SVH
`define SORTABLE_SEARCH_FIFO_TOP_DEFINES_SVH

// check outside reset only
`define SSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define SSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/ssf_pkg.sv
// ----------------------------------------------------------------------------
// Sortable search FIFO package
// Sizes, operation codes, transaction types and word conversions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssf_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_SORT = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic [31:0] head_value;
    logic [31:0] tail_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        hit;
    logic [31:0] hit_value;
    logic        error;
  } out_t;

  function automatic word_t from_field(logic [31:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to_field(word_t w);
    logic [63:0] e;
    e = 64'(w);
    return e[31:0];
  endfunction

endpackage

### design/ssf_ram.sv
// ----------------------------------------------------------------------------
// Sortable search FIFO RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssf_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/sortable_search_fifo_top.sv
// ----------------------------------------------------------------------------
// Sortable search FIFO
// Bounded FIFO of words with push, pop, find and stable ascending sort.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_stall_o stays high until its result
// is queued in the output register. The single read port of the entry RAM
// and the one shared comparator set the pace: find scans one entry a cycle,
// sort runs N - 1 bubble passes of one entry a cycle for N >= 2 stored
// entries, and every operation ends with a head read and a tail read. A new
// transaction is accepted while the previous result still waits on
// out_stall_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sortable_search_fifo_top_defines.svh"

module sortable_search_fifo_top import ssf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_SORT_LD,
    S_SORT_STEP,
    S_SORT_END,
    S_RD_HEAD,
    S_RD_TAIL,
    S_DONE
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic [AW-1:0]  hptr_q;
  logic [AW-1:0]  idx_q;
  logic [AW-1:0]  pass_q;
  word_t          query_q;
  word_t          cur_q;
  word_t          head_q;
  logic           hit_q;
  logic           err_q;
  logic           out_valid_q;
  out_t           out_data_q;

  logic           in_acc;
  logic           full;
  logic [CW-1:0]  cnt_m1;
  logic [CW-1:0]  cnt_m2;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  lraddr;
  logic [AW-1:0]  raddr;
  logic           we;
  logic [AW-1:0]  waddr;
  word_t          wdata;
  word_t          rdata;
  word_t          cmp_a;
  word_t          cmp_b;
  logic           cmp_eq;
  logic           cmp_gt;

  function automatic logic [AW-1:0] phys(logic [AW-1:0] base, logic [AW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, l};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign full       = (count_q == CW'(DEPTH));
  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign last_idx   = cnt_m1[AW-1:0];

  always_comb begin
    cmp_a = rdata;
    cmp_b = query_q;
    if (state_q == S_SORT_STEP) begin
      cmp_a = cur_q;
      cmp_b = rdata;
    end
  end

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_gt = (cmp_a > cmp_b);

  always_comb begin
    case (state_q)
      S_FIND, S_SORT_STEP: lraddr = idx_q + AW'(1);
      S_SORT_LD:           lraddr = AW'(1);
      S_RD_TAIL, S_DONE:   lraddr = last_idx;
      default:             lraddr = '0;
    endcase
  end

  assign raddr = phys(hptr_q, lraddr);

  always_comb begin
    we    = 1'b0;
    waddr = phys(hptr_q, count_q[AW-1:0]);
    wdata = from_field(in_data_i.value_in);
    case (state_q)
      S_IDLE: begin
        we = in_acc && (in_data_i.op == OP_PUSH) && !full;
      end
      S_SORT_STEP: begin
        we    = 1'b1;
        waddr = phys(hptr_q, idx_q - AW'(1));
        wdata = cmp_gt ? rdata : cur_q;
      end
      S_SORT_END: begin
        we    = 1'b1;
        waddr = phys(hptr_q, last_idx);
        wdata = cur_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ssf_ram #(
    .Width (WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hptr_q      <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      query_q     <= '0;
      cur_q       <= '0;
      head_q      <= '0;
      hit_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            query_q <= from_field(in_data_i.value_in);
            hit_q   <= 1'b0;
            err_q   <= 1'b0;
            idx_q   <= '0;
            pass_q  <= '0;
            state_q <= S_RD_HEAD;
            case (in_data_i.op)
              OP_PUSH: begin
                if (full) begin
                  err_q <= 1'b1;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              OP_POP: begin
                if (count_q == '0) begin
                  err_q <= 1'b1;
                end else begin
                  count_q <= cnt_m1;
                  hptr_q  <= phys(hptr_q, AW'(1));
                end
              end
              OP_FIND: begin
                if (count_q != '0) begin
                  state_q <= S_FIND;
                end
              end
              default: begin
                if (count_q > CW'(1)) begin
                  state_q <= S_SORT_LD;
                end
              end
            endcase
          end
        end
        S_FIND: begin
          if (cmp_eq) begin
            hit_q <= 1'b1;
          end
          if (idx_q == last_idx) begin
            state_q <= S_RD_HEAD;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_SORT_LD: begin
          cur_q   <= rdata;
          idx_q   <= AW'(1);
          state_q <= S_SORT_STEP;
        end
        S_SORT_STEP: begin
          cur_q <= cmp_gt ? cur_q : rdata;
          if (idx_q == last_idx) begin
            state_q <= S_SORT_END;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_SORT_END: begin
          if (pass_q == cnt_m2[AW-1:0]) begin
            state_q <= S_RD_HEAD;
          end else begin
            pass_q  <= pass_q + AW'(1);
            state_q <= S_SORT_LD;
          end
        end
        S_RD_HEAD: begin
          state_q <= S_RD_TAIL;
        end
        S_RD_TAIL: begin
          head_q  <= rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.head_value  <= (count_q != '0) ? to_field(head_q) : 32'd0;
            out_data_q.tail_value  <= (count_q != '0) ? to_field(rdata) : 32'd0;
            out_data_q.entry_count <= 5'(count_q);
            out_data_q.is_empty    <= (count_q == '0);
            out_data_q.hit         <= hit_q;
            out_data_q.hit_value   <= hit_q ? to_field(query_q) : 32'd0;
            out_data_q.error       <= err_q;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SSF_ASSERT_ALWAYS(a_count_bound, (count_q <= CW'(DEPTH)), "entry count above depth")
  `SSF_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")
  `SSF_ASSERT(a_push_grows, (in_acc && (in_data_i.op == OP_PUSH) && !full) |=> (count_q == $past(count_q) + CW'(1)), "push did not add an entry")
  `SSF_ASSERT(a_err_no_hit, out_valid_o |-> !(out_data_o.error && out_data_o.hit), "error and hit together")

endmodule

### bench/ssf_checker.sv
// ----------------------------------------------------------------------------
// Sortable search FIFO checker
// Watches both channels of the block. Every accepted input transaction goes
// through a local model of the queue, which yields the expected status. Every
// accepted output transaction is compared field by field with the oldest
// expected status. The failure count and the number of outstanding
// expectations go back to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssf_checker import ssf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int MAX_REPORTS = 10;

  word_t queue_words [DEPTH];
  int    fill;
  out_t  expected_status_q [$];
  int    fail_count;
  int    reports;

  function automatic out_t apply_queue_op(in_t t);
    out_t  r;
    word_t v;
    word_t key;
    int    j;
    r = '0;
    v = word_t'(t.value_in);
    case (t.op)
      OP_PUSH: begin
        if (fill >= DEPTH) begin
          r.error = 1'b1;
        end else begin
          queue_words[fill] = v;
          fill++;
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          r.error = 1'b1;
        end else begin
          for (int i = 1; i < fill; i++) queue_words[i-1] = queue_words[i];
          fill--;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < fill; i++) begin
          if (queue_words[i] == v) begin
            r.hit       = 1'b1;
            r.hit_value = 32'(queue_words[i]);
            break;
          end
        end
      end
      default: begin
        // stable insertion sort: shift only strictly greater entries
        for (int i = 1; i < fill; i++) begin
          key = queue_words[i];
          j   = i;
          while (j > 0 && queue_words[j-1] > key) begin
            queue_words[j] = queue_words[j-1];
            j--;
          end
          queue_words[j] = key;
        end
      end
    endcase
    if (fill != 0) begin
      r.head_value = 32'(queue_words[0]);
      r.tail_value = 32'(queue_words[fill-1]);
    end
    r.entry_count = 5'(fill);
    r.is_empty    = (fill == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      fill = 0;
      expected_status_q.delete();
      fail_count = 0;
      reports    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("[%0t] unexpected output transaction %h", $time, out_data_i);
          end
        end else begin
          want = expected_status_q.pop_front();
          check_field("head_value",  want.head_value,  out_data_i.head_value);
          check_field("tail_value",  want.tail_value,  out_data_i.tail_value);
          check_field("entry_count", 32'(want.entry_count), 32'(out_data_i.entry_count));
          check_field("is_empty",    32'(want.is_empty),    32'(out_data_i.is_empty));
          check_field("hit",         32'(want.hit),         32'(out_data_i.hit));
          check_field("hit_value",   want.hit_value,   out_data_i.hit_value);
          check_field("error",       32'(want.error),       32'(out_data_i.error));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_status_q.push_back(apply_queue_op(in_data_i));
      end
      fail_count_o <= fail_count;
      pending_o    <= expected_status_q.size();
    end
  end

endmodule

### bench/tb_sortable_search_fifo_top.sv
// ----------------------------------------------------------------------------
// Sortable search FIFO testbench
// Drives push, pop, find and sort transactions into the block: a directed
// opening on empty, duplicate and extreme values, then random traffic in
// fill, drain and mixed phases with random idle cycles on both channels.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sortable_search_fifo_top;
  import ssf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          DRAIN_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  logic        calm;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  logic [31:0] recent [8];
  int          recent_wr;

  sortable_search_fifo_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  ssf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sortable_search_fifo_top NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(bit query);
    logic [31:0] v;
    int unsigned r;
    r = $urandom_range(9);
    if (query && r < 4) begin
      v = recent[$urandom_range(7)];
    end else if (r < 6) begin
      v = 32'($urandom_range(7));
    end else if (r == 6) begin
      case ($urandom_range(3))
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h8000_0000;
        default: v = 32'h7FFF_FFFF;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic op_e pick_op(int mode);
    int unsigned r;
    r = $urandom_range(99);
    case (mode)
      0: begin
        if (r < 65) return OP_PUSH;
        if (r < 80) return OP_POP;
        if (r < 95) return OP_FIND;
        return OP_SORT;
      end
      1: begin
        if (r < 15) return OP_PUSH;
        if (r < 80) return OP_POP;
        if (r < 95) return OP_FIND;
        return OP_SORT;
      end
      default: begin
        if (r < 35) return OP_PUSH;
        if (r < 65) return OP_POP;
        if (r < 90) return OP_FIND;
        return OP_SORT;
      end
    endcase
  endfunction

  // hold valid and payload until the transaction is accepted
  task automatic send(op_e op, logic [31:0] v);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op, value_in: v};
    if (op == OP_PUSH) begin
      recent[recent_wr] = v;
      recent_wr = (recent_wr + 1) % 8;
    end
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    op_e op;
    int  mode;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    calm        <= 1'b0;
    recent_wr   = 0;
    mode        = 2;
    for (int i = 0; i < 8; i++) recent[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OP_SORT, 32'h0000_0000);
    send(OP_FIND, 32'h0000_0000);
    send(OP_POP,  32'hFFFF_FFFF);
    send(OP_PUSH, 32'h0000_0000);
    send(OP_FIND, 32'h0000_0000);
    send(OP_PUSH, 32'hFFFF_FFFF);
    send(OP_PUSH, 32'h8000_0000);
    send(OP_PUSH, 32'h7FFF_FFFF);
    send(OP_PUSH, 32'h0000_0001);
    send(OP_PUSH, 32'h0000_0001);
    send(OP_FIND, 32'hFFFF_FFFF);
    send(OP_FIND, 32'h0000_0002);
    send(OP_FIND, 32'h0000_0001);
    send(OP_SORT, 32'h0000_0000);
    send(OP_POP,  32'h0000_0000);
    send(OP_FIND, 32'h0000_0000);
    send(OP_PUSH, 32'h0000_0000);
    send(OP_SORT, 32'hFFFF_FFFF);
    send(OP_POP,  32'h0000_0000);
    send(OP_POP,  32'h0000_0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) mode = $urandom_range(2);
      calm <= (n >= 500 && n < 700);
      op = pick_op(mode);
      send(op, pick_value(op == OP_FIND));
    end

    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sortable_search_fifo_top OK");
    end else begin
      $display("tb_sortable_search_fifo_top NOT OK");
    end
    $finish;
  end

endmodule
